### hw/rtl/fscull_pkg.sv
package fscull_pkg;

  localparam int COORD_BITS = 21;
  localparam int RADIUS_BITS = COORD_BITS - 1;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int AXIS_BITS = 20;
  localparam int PROJ_BITS = 44;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_CAM_POS  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAM_ROT  = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEAR     = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAR      = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAN      = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ASPECT   = 8'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_W_SCALE  = 8'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_H_SCALE  = 8'd7;

  localparam logic [63:0] ROT_RESET = 64'd16384;
  localparam logic [15:0] SCALE_RESET = 16'd4096;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] x;
    logic signed [AXIS_BITS-1:0] y;
    logic signed [AXIS_BITS-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t fwd;
    vec_t rgt;
    vec_t upv;
  } axes_t;

  typedef struct packed {
    logic [3*COORD_BITS-1:0] cam_pos;
    logic [19:0]             near_dist;
    logic [19:0]             far_dist;
    logic [15:0]             tan_half;
    logic [15:0]             aspect;
    logic [15:0]             w_scale;
    logic [15:0]             h_scale;
  } view_cfg_t;

  // Q.28 to Q.14, round half up (floor of v + 2^13).
  function automatic logic signed [AXIS_BITS-1:0] round_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd8192) >>> 14;
    return t[AXIS_BITS-1:0];
  endfunction

endpackage

### hw/rtl/fscull_if.sv
interface fscull_item_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fscull_pkg::COORD_BITS-1:0] center_x;
  logic signed [fscull_pkg::COORD_BITS-1:0] center_y;
  logic signed [fscull_pkg::COORD_BITS-1:0] center_z;
  logic [fscull_pkg::RADIUS_BITS-1:0]       sphere_radius;
  modport source(output valid, center_x, center_y, center_z, sphere_radius, input ready);
  modport sink(input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface fscull_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source(output valid, inside_res, input ready);
  modport sink(input valid, inside_res, output ready);
endinterface

interface fscull_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [fscull_pkg::CFG_IDX_BITS-1:0]   index;
  logic [fscull_pkg::CFG_DATA_BITS-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/frustum_sphere_cull_test_core.sv
// Sphere / view-frustum cull test.
//
// Channels: item (sink) carries center_x/y/z and sphere_radius; result (source)
// carries inside_res, one per item, in order. cfg (sink) writes the eight view
// registers by index; it is always ready and a write to an unknown index is dropped.
// Write cfg only while no item is in flight; the derived camera axes follow a
// rotation write through a register of their own in fscull_axis.
//
// Throughput: one item per cycle unless the output stalls. The result comes out of
// six register stages (offset, projection dot products, width limit multiply and
// depth check, width floor and check, height limit multiply, height check).
//
// Reset clears all stage valid bits and loads the register defaults (identity
// rotation, unit radius scales, zeros elsewhere).
// When result.ready is low with a result waiting, the whole pipeline holds and
// item.ready drops; nothing is lost or repeated.
module frustum_sphere_cull_test_core (
  input  logic                  clk,
  input  logic                  rst,
  fscull_item_if.sink           item,
  fscull_result_if.source       result,
  fscull_cfg_if.sink            cfg
);

  fscull_pkg::view_cfg_t view;
  logic [63:0]           cam_rot;
  fscull_pkg::axes_t     axes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view.cam_pos   <= '0;
      cam_rot        <= fscull_pkg::ROT_RESET;
      view.near_dist <= '0;
      view.far_dist  <= '0;
      view.tan_half  <= '0;
      view.aspect    <= '0;
      view.w_scale   <= fscull_pkg::SCALE_RESET;
      view.h_scale   <= fscull_pkg::SCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fscull_pkg::REG_CAM_POS: view.cam_pos   <= cfg.data[62:0];
        fscull_pkg::REG_CAM_ROT: cam_rot        <= cfg.data;
        fscull_pkg::REG_NEAR:    view.near_dist <= cfg.data[19:0];
        fscull_pkg::REG_FAR:     view.far_dist  <= cfg.data[19:0];
        fscull_pkg::REG_TAN:     view.tan_half  <= cfg.data[15:0];
        fscull_pkg::REG_ASPECT:  view.aspect    <= cfg.data[15:0];
        fscull_pkg::REG_W_SCALE: view.w_scale   <= cfg.data[15:0];
        fscull_pkg::REG_H_SCALE: view.h_scale   <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  fscull_axis u_axis (
    .clk      (clk),
    .rotation (cam_rot),
    .axes     (axes)
  );

  fscull_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (view),
    .axes      (axes),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .cx        (item.center_x),
    .cy        (item.center_y),
    .cz        (item.center_z),
    .rad       (item.sphere_radius),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (result.inside_res)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !item.ready)
    else $error("item taken while result stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  a_cam_pos_write: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && cfg.index == fscull_pkg::REG_CAM_POS
      |=> view.cam_pos == $past(cfg.data[62:0]))
    else $error("camera position write lost");

endmodule

### hw/rtl/fscull_axis.sv
module fscull_axis (
  input  logic                clk,
  input  logic [63:0]         rotation,
  output fscull_pkg::axes_t   axes
);

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  fscull_pkg::axes_t  axes_next;

  always_comb begin
    qw = rotation[15:0];
    qx = rotation[31:16];
    qy = rotation[47:32];
    qz = rotation[63:48];
    ww = qw * qw;
    xx = qx * qx;
    yy = qy * qy;
    zz = qz * qz;
    xy = qx * qy;
    wz = qw * qz;
    xz = qx * qz;
    wy = qw * qy;
    yz = qy * qz;
    wx = qw * qx;
    axes_next.rgt.x = fscull_pkg::round_q14(34'(ww) + 34'(xx) - 34'(yy) - 34'(zz));
    axes_next.rgt.y = fscull_pkg::round_q14((34'(xy) + 34'(wz)) <<< 1);
    axes_next.rgt.z = fscull_pkg::round_q14((34'(xz) - 34'(wy)) <<< 1);
    axes_next.upv.x = fscull_pkg::round_q14((34'(xy) - 34'(wz)) <<< 1);
    axes_next.upv.y = fscull_pkg::round_q14(34'(ww) - 34'(xx) + 34'(yy) - 34'(zz));
    axes_next.upv.z = fscull_pkg::round_q14((34'(yz) + 34'(wx)) <<< 1);
    axes_next.fwd.x = fscull_pkg::round_q14(-((34'(xz) + 34'(wy)) <<< 1));
    axes_next.fwd.y = fscull_pkg::round_q14(-((34'(yz) - 34'(wx)) <<< 1));
    axes_next.fwd.z = fscull_pkg::round_q14(-(34'(ww) - 34'(xx) - 34'(yy) + 34'(zz)));
  end

  // Registered, so the axes follow the rotation register in the next cycle.
  always_ff @(posedge clk) begin
    axes <= axes_next;
  end

endmodule

### hw/rtl/fscull_pipe.sv
module fscull_pipe (
  input  logic                                     clk,
  input  logic                                     rst,
  input  fscull_pkg::view_cfg_t                    cfg,
  input  fscull_pkg::axes_t                        axes,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [fscull_pkg::COORD_BITS-1:0] cx,
  input  logic signed [fscull_pkg::COORD_BITS-1:0] cy,
  input  logic signed [fscull_pkg::COORD_BITS-1:0] cz,
  input  logic [fscull_pkg::RADIUS_BITS-1:0]       rad,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     res
);

  localparam int CB = fscull_pkg::COORD_BITS;
  localparam int DB = fscull_pkg::DIFF_BITS;
  localparam int PB = fscull_pkg::PROJ_BITS;

  logic en;
  logic v1, v2, v3, v4, v5;

  // stage 1
  logic signed [DB-1:0] p1x, p1y, p1z;
  logic [fscull_pkg::RADIUS_BITS-1:0] r1;
  // stage 2
  logic signed [PB-1:0] d2, s2, h2;
  logic signed [20:0]   lo2;
  logic signed [21:0]   hi2;
  logic [35:0]          wr2, hr2;
  // stage 3
  logic signed [60:0]   tw3;
  logic signed [PB-1:0] s3, h3;
  logic [35:0]          wr3, hr3;
  logic                 dok3;
  // stage 4
  logic signed [49:0]   wl4;
  logic signed [PB-1:0] h4;
  logic [35:0]          hr4;
  logic                 ok4;
  // stage 5
  logic signed [63:0]   am5;
  logic signed [PB-1:0] h5;
  logic [35:0]          hr5;
  logic                 ok5;

  logic signed [PB-1:0] lo_ext, hi_ext;
  logic signed [61:0]   wl_full, s_sc;
  logic signed [63:0]   hl_full, h_sc;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    lo_ext  = PB'(lo2) <<< 14;
    hi_ext  = PB'(hi2) <<< 14;
    wl_full = 62'(tw3) + $signed({12'd0, wr3, 14'd0});
    s_sc    = 62'(s3) <<< 12;
    hl_full = am5 + $signed({14'd0, hr5, 14'd0});
    h_sc    = 64'(h5) <<< 12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1x <= DB'(cx) - DB'($signed(cfg.cam_pos[0 +: CB]));
      p1y <= DB'(cy) - DB'($signed(cfg.cam_pos[CB +: CB]));
      p1z <= DB'(cz) - DB'($signed(cfg.cam_pos[2*CB +: CB]));
      r1  <= rad;

      d2  <= PB'(p1x * axes.fwd.x) + PB'(p1y * axes.fwd.y) + PB'(p1z * axes.fwd.z);
      s2  <= PB'(p1x * axes.rgt.x) + PB'(p1y * axes.rgt.y) + PB'(p1z * axes.rgt.z);
      h2  <= PB'(p1x * axes.upv.x) + PB'(p1y * axes.upv.y) + PB'(p1z * axes.upv.z);
      lo2 <= $signed({1'b0, cfg.near_dist}) - $signed({1'b0, r1});
      hi2 <= $signed({2'b0, cfg.far_dist}) + $signed({2'b0, r1});
      wr2 <= 36'(cfg.w_scale) * 36'(r1);
      hr2 <= 36'(cfg.h_scale) * 36'(r1);

      tw3  <= 61'($signed({1'b0, cfg.tan_half})) * 61'(d2);
      dok3 <= (d2 >= lo_ext) && (d2 <= hi_ext);
      s3   <= s2;
      h3   <= h2;
      wr3  <= wr2;
      hr3  <= hr2;

      // floor the width limit to the projection scale before aspect
      wl4 <= 50'(wl_full >>> 12);
      ok4 <= dok3 && !wl_full[61] && (s_sc >= -wl_full) && (s_sc <= wl_full);
      h4  <= h3;
      hr4 <= hr3;

      am5 <= 64'($signed({1'b0, cfg.aspect})) * 64'(wl4);
      ok5 <= ok4;
      h5  <= h4;
      hr5 <= hr4;

      res <= ok5 && !hl_full[63] && (h_sc >= -hl_full) && (h_sc <= hl_full);
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fscull_item_if   item_ch();
  fscull_result_if result_ch();
  fscull_cfg_if    cfg_ch();

  frustum_sphere_cull_test_core dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // view registers as the predictor sees them
  logic [63:0] view_pos;
  logic [63:0] view_rot;
  longint near_d, far_d, tan_h, aspect_f, w_scale, h_scale;

  bit     inside_expected[$];
  int     errors = 0;
  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;
  int     rx_hold_req = 0;
  int     rx_stall_left = 0;

  function automatic longint to_q14(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic bit in_range(longint v, longint lim);
    return lim >= 0 && v >= -lim && v <= lim;
  endfunction

  function automatic bit cull_inside(logic signed [fscull_pkg::COORD_BITS-1:0] cx,
                                     logic signed [fscull_pkg::COORD_BITS-1:0] cy,
                                     logic signed [fscull_pkg::COORD_BITS-1:0] cz,
                                     logic [fscull_pkg::RADIUS_BITS-1:0] rad);
    longint w, x, y, z, ww, xx, yy, zz, r;
    longint fw[3], rg[3], up[3], p[3];
    longint d, s, h, lo, hi, wl, wl14, hl;
    w = $signed(view_rot[15:0]);
    x = $signed(view_rot[31:16]);
    y = $signed(view_rot[47:32]);
    z = $signed(view_rot[63:48]);
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    rg[0] = to_q14(ww + xx - yy - zz);
    rg[1] = to_q14(2 * (x * y + w * z));
    rg[2] = to_q14(2 * (x * z - w * y));
    up[0] = to_q14(2 * (x * y - w * z));
    up[1] = to_q14(ww - xx + yy - zz);
    up[2] = to_q14(2 * (y * z + w * x));
    fw[0] = to_q14(-2 * (x * z + w * y));
    fw[1] = to_q14(-2 * (y * z - w * x));
    fw[2] = to_q14(-(ww - xx - yy + zz));
    p[0] = longint'(cx) - longint'($signed(view_pos[20:0]));
    p[1] = longint'(cy) - longint'($signed(view_pos[41:21]));
    p[2] = longint'(cz) - longint'($signed(view_pos[62:42]));
    r = longint'({44'd0, rad});
    d = p[0] * fw[0] + p[1] * fw[1] + p[2] * fw[2];
    s = p[0] * rg[0] + p[1] * rg[1] + p[2] * rg[2];
    h = p[0] * up[0] + p[1] * up[1] + p[2] * up[2];
    lo = (near_d - r) * 16384;
    hi = (far_d + r) * 16384;
    wl = tan_h * d + w_scale * r * 16384;
    wl14 = wl >>> 12;
    hl = aspect_f * wl14 + h_scale * r * 16384;
    return d >= lo && d <= hi && in_range(s * 4096, wl) && in_range(h * 4096, hl);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("tb: mismatch %s expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // predict on every accepted item transfer
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      inside_expected.push_back(cull_inside(item_ch.center_x, item_ch.center_y,
                                            item_ch.center_z, item_ch.sphere_radius));
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (inside_expected.size() == 0) begin
        report_mismatch("unexpected result", -1, result_ch.inside_res);
      end else begin
        bit exp_in;
        exp_in = inside_expected.pop_front();
        if (result_ch.inside_res !== exp_in)
          report_mismatch("inside_res", exp_in, result_ch.inside_res);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_stall_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_stall_left > 0) begin
      result_ch.ready = 1'b0;
      rx_stall_left--;
    end else begin
      result_ch.ready = 1'b1;
      if (!rx_steady && $urandom_range(0, 9) < 3) rx_stall_left = gap_len();
    end
  end

  task automatic send_item(logic signed [fscull_pkg::COORD_BITS-1:0] cx,
                           logic signed [fscull_pkg::COORD_BITS-1:0] cy,
                           logic signed [fscull_pkg::COORD_BITS-1:0] cz,
                           logic [fscull_pkg::RADIUS_BITS-1:0] rad);
    int gap;
    gap = (tx_steady || $urandom_range(0, 9) < 7) ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
    end
    @(negedge clk);
    item_ch.valid = 1'b1;
    item_ch.center_x = cx;
    item_ch.center_y = cy;
    item_ch.center_z = cz;
    item_ch.sphere_radius = rad;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (inside_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [fscull_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      fscull_pkg::REG_CAM_POS: view_pos = {1'b0, value[62:0]};
      fscull_pkg::REG_CAM_ROT: view_rot = value;
      fscull_pkg::REG_NEAR:    near_d = longint'({44'd0, value[19:0]});
      fscull_pkg::REG_FAR:     far_d = longint'({44'd0, value[19:0]});
      fscull_pkg::REG_TAN:     tan_h = longint'({48'd0, value[15:0]});
      fscull_pkg::REG_ASPECT:  aspect_f = longint'({48'd0, value[15:0]});
      fscull_pkg::REG_W_SCALE: w_scale = longint'({48'd0, value[15:0]});
      fscull_pkg::REG_H_SCALE: h_scale = longint'({48'd0, value[15:0]});
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic set_view(logic [62:0] pos, logic [63:0] rot, logic [19:0] nr, logic [19:0] fr,
                          logic [15:0] tn, logic [15:0] asp, logic [15:0] ws, logic [15:0] hs);
    cfg_write(fscull_pkg::REG_CAM_POS, {1'b0, pos});
    cfg_write(fscull_pkg::REG_CAM_ROT, rot);
    cfg_write(fscull_pkg::REG_NEAR, {44'd0, nr});
    cfg_write(fscull_pkg::REG_FAR, {44'd0, fr});
    cfg_write(fscull_pkg::REG_TAN, {48'd0, tn});
    cfg_write(fscull_pkg::REG_ASPECT, {48'd0, asp});
    cfg_write(fscull_pkg::REG_W_SCALE, {48'd0, ws});
    cfg_write(fscull_pkg::REG_H_SCALE, {48'd0, hs});
  endtask

  task automatic test_reset_view();
    send_item('0, '0, '0, '0);
    send_item('0, '0, -21'sd1, '0);
    send_item('0, '0, '0, 20'hFFFFF);
    send_item(21'sh100000, 21'sh0FFFFF, 21'sh100000, 20'd1);
    wait_drained();
  endtask

  task automatic test_directed();
    // 45 degree half angle, 4:3, camera at origin looking down -z
    set_view('0, fscull_pkg::ROT_RESET, 20'd256, 20'd65536, 16'd4096, 16'd3072, 16'd5793,
             16'd5120);
    send_item('0, '0, -21'sd1024, '0);
    send_item(21'sd1024, '0, -21'sd1024, '0);
    send_item(21'sd1025, '0, -21'sd1024, '0);
    send_item('0, 21'sd768, -21'sd1024, '0);
    send_item('0, 21'sd769, -21'sd1024, '0);
    send_item('0, '0, -21'sd255, '0);
    send_item('0, '0, -21'sd256, '0);
    send_item('0, '0, -21'sd65536, '0);
    send_item('0, '0, -21'sd65537, '0);
    send_item('0, '0, -21'sd65600, 20'd100);
    // behind the camera with a radius smaller than the gap: depth check fails
    send_item('0, '0, 21'sd4096, 20'd300);
    send_item(21'sh0FFFFF, 21'sh100000, 21'sh100000, 20'hFFFFF);
    send_item(21'sh100000, 21'sh0FFFFF, 21'sh0FFFFF, 20'hFFFFF);
    wait_drained();
    // dropped index and over-wide value
    cfg_write(fscull_pkg::REG_H_SCALE + 8'd1, 64'd12345);
    cfg_write('1, '1);
    cfg_write(fscull_pkg::REG_NEAR, '1);
    send_item('0, '0, -21'sd1024, '0);
    wait_drained();
    cfg_write(fscull_pkg::REG_NEAR, 64'd256);
    // non-unit quaternion, then a 90 degree turn about y
    cfg_write(fscull_pkg::REG_CAM_ROT, {16'd0, 16'd0, 16'd0, 16'd20000});
    send_item('0, '0, -21'sd1024, '0);
    send_item(21'sd1500, '0, -21'sd1024, '0);
    wait_drained();
    cfg_write(fscull_pkg::REG_CAM_ROT, {16'd0, 16'd11585, 16'd0, 16'd11585});
    send_item(-21'sd1024, '0, '0, '0);
    send_item('0, '0, -21'sd1024, '0);
    wait_drained();
  endtask

  function automatic logic [63:0] pick_rotation();
    case ($urandom_range(0, 5))
      0: return fscull_pkg::ROT_RESET;
      1: return {16'd0, 16'd0, 16'd11585, 16'd11585};
      2: return {16'd11585, 16'd0, 16'd0, 16'd11585};
      3: return {16'd0, 16'd0, 16'd0, 16'hC000};
      4: return {$urandom(), $urandom()};
      default: return {16'(8192 - $urandom_range(0, 16384)), 16'(8192 - $urandom_range(0, 16384)),
                       16'(8192 - $urandom_range(0, 16384)), 16'(8192 + $urandom_range(0, 8192))};
    endcase
  endfunction

  task automatic random_phase(int n_items, bit extreme);
    logic [62:0] pos;
    logic signed [fscull_pkg::COORD_BITS-1:0] px, py, pz;
    int k;
    if (extreme) begin
      pos = 63'({$urandom(), $urandom()});
      px = pos[20:0];
      py = pos[41:21];
      pz = pos[62:42];
      set_view(pos, {$urandom(), $urandom()}, 20'($urandom()), 20'($urandom()),
               16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end else begin
      px = 21'($urandom_range(0, 8191)) - 21'sd4096;
      py = 21'($urandom_range(0, 8191)) - 21'sd4096;
      pz = 21'($urandom_range(0, 8191)) - 21'sd4096;
      pos = {pz, py, px};
      set_view(pos, pick_rotation(), 20'($urandom_range(0, 2048)),
               20'($urandom_range(4096, 200000)),
               16'($urandom_range(1024, 12000)), 16'($urandom_range(1024, 8192)),
               16'($urandom_range(4096, 12000)), 16'($urandom_range(4096, 12000)));
    end
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) < 8)
        // around the camera, where all three checks matter
        send_item(px + 21'($urandom_range(0, 16383)) - 21'sd8192,
                  py + 21'($urandom_range(0, 16383)) - 21'sd8192,
                  pz + 21'($urandom_range(0, 16383)) - 21'sd8192,
                  ($urandom_range(0, 3) == 0) ? '0 : 20'($urandom_range(0, 2048)));
      else
        send_item(21'($urandom()), 21'($urandom()), 21'($urandom()), 20'($urandom()));
    end
    wait_drained();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random();
    random_phase(40, 1'b1);
    repeat (5) random_phase(55, 1'b0);
    random_phase(30, 1'b1);
    set_view('0, fscull_pkg::ROT_RESET, '0, '0, '0, '0, '0, '0);
    random_phase(10, 1'b0);
  endtask

  task automatic test_backpressure();
    int k;
    tx_steady = 1'b1;
    @(negedge clk);
    rx_hold_req = 120;
    for (k = 0; k < 40; k++)
      send_item(21'($urandom_range(0, 4095)) - 21'sd2048, 21'($urandom_range(0, 4095)) - 21'sd2048,
                -21'($urandom_range(0, 8191)), 20'($urandom_range(0, 512)));
    wait_drained();
    tx_steady = 1'b0;
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.center_x = '0;
    item_ch.center_y = '0;
    item_ch.center_z = '0;
    item_ch.sphere_radius = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    result_ch.ready = 1'b0;
    view_pos = '0;
    view_rot = fscull_pkg::ROT_RESET;
    near_d = 0; far_d = 0; tan_h = 0; aspect_f = 0;
    w_scale = longint'({48'd0, fscull_pkg::SCALE_RESET});
    h_scale = longint'({48'd0, fscull_pkg::SCALE_RESET});
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_view();
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
